// ===== hw/rtl/tkps_pkg.sv =====
// Shared types and constants for the top-k scored pair selector.
package tkps_pkg;

  localparam int Capacity = 1024;
  localparam int IdxW     = $clog2(Capacity);
  localparam int FillW    = $clog2(Capacity + 1);
  localparam int ScoreW   = 13;
  localparam int GeneW    = 12;
  localparam int AgeW     = 32;
  localparam int RankW    = 10;
  localparam int StatW    = 3;

  localparam logic [StatW-1:0] StBelowThr = 3'd0;
  localparam logic [StatW-1:0] StInserted = 3'd1;
  localparam logic [StatW-1:0] StReplaced = 3'd2;
  localparam logic [StatW-1:0] StBelowMin = 3'd3;
  localparam logic [StatW-1:0] StExtract  = 3'd4;
  localparam logic [StatW-1:0] StEmpty    = 3'd5;

  localparam logic RegMinWeight = 1'b0;
  localparam logic RegMaxWeight = 1'b1;

  localparam logic OpOffer   = 1'b0;
  localparam logic OpExtract = 1'b1;

  typedef struct packed {
    logic              op;
    logic [GeneW-1:0]  first_index;
    logic [GeneW-1:0]  second_index;
    logic [ScoreW-1:0] direct_count;
    logic [ScoreW-1:0] alternate_count;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [GeneW-1:0]  out_first;
    logic [GeneW-1:0]  out_second;
    logic              out_alternate;
    logic [ScoreW-1:0] out_score;
    logic [RankW-1:0]  out_rank;
    logic [FillW-1:0]  fill;
  } out_item_t;

  typedef struct packed {
    logic [GeneW-1:0]  first;
    logic [GeneW-1:0]  second;
    logic              alt;
    logic [ScoreW-1:0] score;
    logic [AgeW-1:0]   age;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_LAST_RD,
    S_LAST_WR,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load_item;
    logic set_thr;
    logic insert;
    logic set_empty;
    logic scan_start;
    logic scan_run;
    logic replace;
    logic read_last;
    logic extract;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic is_extract;
    logic below_thr;
    logic not_full;
    logic empty;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/tkps_in_if.sv =====
// Request channel carrying offer and extract items.
interface tkps_in_if import tkps_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tkps_out_if.sv =====
// Result channel.
interface tkps_out_if import tkps_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/top_k_scored_pair_selector.sv =====
// Top level of the top-k scored pair selector.
// Usage:
//   in_i  : requests; op 0 offers a scored gene pair, op 1 extracts the
//           lowest entry (oldest first on equal scores) with its rank.
//   out_o : one result per request: status, extracted entry fields, fill.
//   cfg   : min_weight (index 0) and max_weight (index 1), written when idle.
// Sequence: an offer rejected by threshold or taken by a non-full store and an
//   empty extract go from the decide state straight to the output state. An
//   offer to a full store scans the entry memory linearly, one read per cycle,
//   then replaces the minimum if it scores higher; a non-empty extract scans,
//   then reads the last entry and moves it into the extracted slot.
// Throughput: one request at a time; the next is taken once the previous
//   result is in the output register.
// Reset: store empty, arrival counter and both weights zero; no clearing pass.
// Stall: a result waits in the output register; a further result waits in
//   its staging register until the receiver takes the first.
module top_k_scored_pair_selector import tkps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ScoreW-1:0] cfg_data_i,
  tkps_in_if.sink           in_i,
  tkps_out_if.source        out_o
);

  cmd_t  cmd;
  stat_t stat;

  tkps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tkps_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (in_i.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule

// ===== hw/rtl/tkps_ctrl.sv =====
// Sequencing state machine for the selector.
module tkps_ctrl import tkps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.is_extract) begin
          if (stat_i.empty) begin
            cmd_o.set_empty = 1'b1;
            state_d         = S_OUT;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = S_SCAN;
          end
        end else if (stat_i.below_thr) begin
          cmd_o.set_thr = 1'b1;
          state_d       = S_OUT;
        end else if (stat_i.not_full) begin
          cmd_o.insert = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          if (stat_i.is_extract) begin
            cmd_o.read_last = 1'b1;
            state_d         = S_LAST_RD;
          end else begin
            cmd_o.replace = 1'b1;
            state_d       = S_OUT;
          end
        end else begin
          cmd_o.scan_run = 1'b1;
        end
      end
      S_LAST_RD: state_d = S_LAST_WR;
      S_LAST_WR: begin
        cmd_o.extract = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/tkps_datapath.sv =====
// Entry store, minimum scan, counters and result registers.
module tkps_datapath import tkps_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [ScoreW-1:0] cfg_data_i,
  input  in_item_t          item_i,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output out_item_t         out_data_o
);

  logic [ScoreW-1:0] min_q, max_q;
  in_item_t          item_q;
  logic [FillW-1:0]  fill_q;
  logic [AgeW-1:0]   arr_q;
  entry_t            mem [Capacity];
  entry_t            rd_data_q;
  logic              rvalid_q;
  logic [FillW-1:0]  cnt_q;
  entry_t            best_q;
  logic [IdxW-1:0]   best_idx_q;
  logic              have_q;
  out_item_t         res_q;
  out_item_t         out_q;
  logic              out_v_q;

  logic              use_alt;
  logic [ScoreW-1:0] score;
  logic [FillW-1:0]  last;
  logic              we;
  logic [IdxW-1:0]   wa;
  entry_t            wd;
  logic              re;
  logic [IdxW-1:0]   ra;
  logic              better;
  logic              out_free;

  assign use_alt  = item_q.direct_count < max_q;
  assign score    = use_alt ? item_q.alternate_count : item_q.direct_count;
  assign last     = fill_q - FillW'(1);
  assign out_free = !out_v_q || out_ready_i;

  assign stat_o.is_extract = item_q.op == OpExtract;
  assign stat_o.below_thr  = score <= min_q;
  assign stat_o.not_full   = fill_q < FillW'(Capacity);
  assign stat_o.empty      = fill_q == '0;
  assign stat_o.scan_done  = cnt_q == fill_q && !rvalid_q;
  assign stat_o.out_free   = out_free;

  assign better = !have_q || rd_data_q.score < best_q.score ||
                  (rd_data_q.score == best_q.score &&
                   (arr_q - rd_data_q.age) > (arr_q - best_q.age));

  always_comb begin
    we = 1'b0;
    wa = fill_q[IdxW-1:0];
    wd = '{first: item_q.first_index, second: item_q.second_index,
           alt: use_alt, score: score, age: arr_q};
    if (cmd_i.insert) begin
      we = 1'b1;
    end else if (cmd_i.replace) begin
      we = score > best_q.score;
      wa = best_idx_q;
    end else if (cmd_i.extract) begin
      we = best_idx_q != last[IdxW-1:0];
      wa = best_idx_q;
      wd = rd_data_q;
    end
    re = 1'b0;
    ra = cnt_q[IdxW-1:0];
    if (cmd_i.scan_run && cnt_q != fill_q) begin
      re = 1'b1;
    end else if (cmd_i.read_last) begin
      re = 1'b1;
      ra = last[IdxW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data_q <= mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      max_q   <= '0;
      fill_q  <= '0;
      arr_q   <= '0;
      rvalid_q <= 1'b0;
      cnt_q   <= '0;
      have_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegMinWeight) min_q <= cfg_data_i;
        if (cfg_idx_i == RegMaxWeight) max_q <= cfg_data_i;
      end
      if (cmd_i.scan_start) begin
        cnt_q    <= '0;
        have_q   <= 1'b0;
        rvalid_q <= 1'b0;
      end else if (cmd_i.scan_run) begin
        rvalid_q <= cnt_q != fill_q;
        if (cnt_q != fill_q) cnt_q <= cnt_q + FillW'(1);
        if (rvalid_q) have_q <= 1'b1;
      end
      if (cmd_i.insert) begin
        fill_q <= fill_q + FillW'(1);
        arr_q  <= arr_q + AgeW'(1);
      end
      if (cmd_i.replace && score > best_q.score) arr_q <= arr_q + AgeW'(1);
      if (cmd_i.extract) fill_q <= last;
      if (cmd_i.publish) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // registered read address, aligned with the read data for the best index
  logic [IdxW-1:0] ridx_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) item_q <= item_i;
    if (re) ridx_q <= ra;
    if (cmd_i.scan_run && rvalid_q && better) begin
      best_q     <= rd_data_q;
      best_idx_q <= ridx_q;
    end
    if (cmd_i.set_thr) begin
      res_q <= '{status: StBelowThr, default: '0};
    end else if (cmd_i.insert) begin
      res_q <= '{status: StInserted, default: '0};
    end else if (cmd_i.set_empty) begin
      res_q <= '{status: StEmpty, default: '0};
    end else if (cmd_i.replace) begin
      res_q <= '{status: (score > best_q.score) ? StReplaced : StBelowMin, default: '0};
    end else if (cmd_i.extract) begin
      res_q <= '{status: StExtract, out_first: best_q.first, out_second: best_q.second,
                 out_alternate: best_q.alt, out_score: best_q.score,
                 out_rank: RankW'(last), fill: '0};
    end
    if (cmd_i.publish) begin
      out_q <= '{status: res_q.status, out_first: res_q.out_first,
                 out_second: res_q.out_second, out_alternate: res_q.out_alternate,
                 out_score: res_q.out_score, out_rank: res_q.out_rank, fill: fill_q};
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(Capacity)) else $error("fill above capacity");
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> fill_q == $past(fill_q) + FillW'(1)) else $error("insert lost");
  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.publish |-> out_free) else $error("result overwritten");
  a_extract_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.extract |-> fill_q != '0) else $error("extract from empty store");
`endif

endmodule
